// File: sv/efqt_pkg.sv
// ----------------------------------------------------------------------------
// efqt_pkg
// Shared types and constants for the encoder frame qualifier and turn tracker.
// ----------------------------------------------------------------------------
package efqt_pkg;

  localparam int ANGLE_BITS    = 14;
  localparam int FRAME_BITS    = 16;
  localparam int TURN_BITS     = 32;
  localparam int POS_BITS      = TURN_BITS + ANGLE_BITS;
  localparam int LIMIT_BITS    = 8;
  localparam int MARGIN_BITS   = 14;
  localparam int CFG_DATA_BITS = 14;
  localparam int CFG_IDX_BITS  = 1;
  localparam int LANES         = 2;

  // frame layout
  localparam int PARITY_BIT = 15;
  localparam int ERRFL_BIT  = 14;

  // reset values of the configuration registers, and the streak ceiling
  localparam logic [LIMIT_BITS-1:0]  FAIL_LIMIT_RST  = 8'd4;
  localparam logic [MARGIN_BITS-1:0] WRAP_MARGIN_RST = 14'd13107;
  localparam logic [LIMIT_BITS-1:0]  STREAK_MAX      = 8'hFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FAIL_LIMIT  = 1'b0,
    REG_WRAP_MARGIN = 1'b1
  } cfg_reg_t;

  // input word kinds
  typedef enum logic {
    OP_READ    = 1'b0,
    OP_RECOVER = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // check result and turn step found by a lane
  typedef struct packed {
    logic valid;
    logic errfl;
    logic [ANGLE_BITS-1:0] angle;
    logic step_dec;
    logic step_inc;
  } lane_res_t;

  // one finished result word
  typedef struct packed {
    status_t status;
    logic [ANGLE_BITS-1:0] angle;
    logic [TURN_BITS-1:0] turns;
    logic errfl_request;
    logic reinit_request;
  } result_t;

endpackage

// File: sv/efqt_lane.sv
// ----------------------------------------------------------------------------
// efqt_lane
// Checks one transfer attempt: bus status and even parity, and works out the
// turn step its angle would cause against the current angle.
// ----------------------------------------------------------------------------
module efqt_lane
  import efqt_pkg::*;
(
  input  logic                   ok,
  input  logic [FRAME_BITS-1:0]  frame,
  input  logic [ANGLE_BITS-1:0]  current_angle,
  input  logic [MARGIN_BITS-1:0] wrap_margin,
  output lane_res_t              res
);

  logic                  parity;
  logic [ANGLE_BITS-1:0] new_angle;
  logic [ANGLE_BITS:0]   jump;
  logic [ANGLE_BITS:0]   mag;
  logic                  big;

  // even parity over the low fifteen bits
  assign parity    = ^frame[PARITY_BIT-1:0];
  assign new_angle = frame[ANGLE_BITS-1:0];

  // signed jump from the current angle and its magnitude
  assign jump = {1'b0, new_angle} - {1'b0, current_angle};
  assign mag  = jump[ANGLE_BITS] ? (~jump + 1'b1) : jump;
  assign big  = mag > {1'b0, wrap_margin};

  always_comb begin
    res.valid    = ok && (parity == frame[PARITY_BIT]);
    res.errfl    = frame[ERRFL_BIT];
    res.angle    = new_angle;
    // positive jump counts a turn down, negative one up
    res.step_dec = big && !jump[ANGLE_BITS];
    res.step_inc = big && jump[ANGLE_BITS];
  end

endmodule

// File: sv/efqt_core.sv
// ----------------------------------------------------------------------------
// efqt_core
// Merges the lane results, holds configuration and tracking state, and
// builds the result word for each accepted input word.
// ----------------------------------------------------------------------------
module efqt_core
  import efqt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     fire,
  input  logic                     op,
  input  lane_res_t                lane_res [LANES],
  output logic [ANGLE_BITS-1:0]    current_angle,
  output logic [MARGIN_BITS-1:0]   wrap_margin,
  output result_t                  result
);

  logic [LIMIT_BITS-1:0] fail_limit;
  logic [LIMIT_BITS-1:0] miss_run, miss_run_next;
  logic                  reinit_flag, reinit_flag_next;
  logic [ANGLE_BITS-1:0] current_angle_next;
  logic [TURN_BITS-1:0]  turn_count, turn_count_next;
  logic [LIMIT_BITS-1:0] streak_inc;
  lane_res_t             pick;
  logic                  take;
  status_t               status;
  logic                  errfl;

  // saturating streak increment
  assign streak_inc = (miss_run == STREAK_MAX) ? miss_run : miss_run + 1'b1;

  // first valid lane wins
  always_comb begin
    pick = lane_res[0].valid ? lane_res[0] : lane_res[1];
    take = lane_res[0].valid || lane_res[1].valid;
  end

  // merge and next state
  always_comb begin
    miss_run_next      = miss_run;
    reinit_flag_next   = reinit_flag;
    current_angle_next = current_angle;
    turn_count_next    = turn_count;
    status             = ST_STALE;
    errfl              = 1'b0;
    if (op == OP_RECOVER) begin
      reinit_flag_next = 1'b0;
      miss_run_next    = '0;
    end else if (reinit_flag) begin
      status = ST_ERROR;
    end else if (take) begin
      errfl              = lane_res[0].valid ? lane_res[0].errfl : 1'b1;
      current_angle_next = pick.angle;
      miss_run_next      = '0;
      status             = ST_OK;
      if (pick.step_dec) begin
        turn_count_next = turn_count - 1'b1;
      end else if (pick.step_inc) begin
        turn_count_next = turn_count + 1'b1;
      end
    end else begin
      errfl = 1'b1;
      if (streak_inc >= fail_limit) begin
        reinit_flag_next = 1'b1;
        miss_run_next    = '0;
        status           = ST_ERROR;
      end else begin
        miss_run_next = streak_inc;
      end
    end
  end

  // result word from the state after this item
  always_comb begin
    result.status         = status;
    result.angle          = current_angle_next;
    result.turns          = turn_count_next;
    result.errfl_request  = errfl;
    result.reinit_request = reinit_flag_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit  <= FAIL_LIMIT_RST;
      wrap_margin <= WRAP_MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FAIL_LIMIT:  fail_limit  <= cfg_data[LIMIT_BITS-1:0];
        REG_WRAP_MARGIN: wrap_margin <= cfg_data[MARGIN_BITS-1:0];
        default:         fail_limit  <= fail_limit;
      endcase
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_run      <= '0;
      reinit_flag   <= 1'b0;
      current_angle <= '0;
      turn_count    <= '0;
    end else if (fire) begin
      miss_run      <= miss_run_next;
      reinit_flag   <= reinit_flag_next;
      current_angle <= current_angle_next;
      turn_count    <= turn_count_next;
    end
  end

endmodule

// File: sv/efqt_obuf.sv
// ----------------------------------------------------------------------------
// efqt_obuf
// Output register with a skid stage, so a new word is taken while a finished
// result still waits downstream.
// ----------------------------------------------------------------------------
module efqt_obuf
  import efqt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign ready = !skid_valid;
  assign pop   = out_valid && out_ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// File: sv/encoder_frame_qualifier_turn_tracker.sv
// ----------------------------------------------------------------------------
// encoder_frame_qualifier_turn_tracker
// An accepted word's result is registered in the output or skid stage.
// One word per cycle while s_tready is high; two check lanes run side by
// side and the state update completes in the cycle the word is accepted.
// A two-deep output buffer keeps s_tready high while one result waits.
// Reset clears state and restores the fail limit (4) and wrap margin (13107).
// ----------------------------------------------------------------------------
module encoder_frame_qualifier_turn_tracker
  import efqt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // input stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // first_ok[0], first_frame[16:1], retry_ok[17], retry_frame[33:18], zero
  input  logic [39:0]              s_tdata,
  // op[0]
  input  logic                     s_tuser,
  // output stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // angle[13:0], turns[45:14], position[91:46], errfl_request[92],
  // reinit_request[93], zero
  output logic [95:0]              m_tdata,
  // status[1:0]
  output logic [1:0]               m_tuser
);

  logic                   fire;
  logic [ANGLE_BITS-1:0]  current_angle;
  logic [MARGIN_BITS-1:0] wrap_margin;
  lane_res_t              lane_res [LANES];
  result_t                result;
  result_t                out_data;
  logic                   buf_ready;

  assign s_tready = buf_ready;
  assign fire     = s_tvalid && buf_ready;

  // check lanes for first and retry attempts
  efqt_lane u_lane0 (
    .ok            (s_tdata[0]),
    .frame         (s_tdata[16:1]),
    .current_angle (current_angle),
    .wrap_margin   (wrap_margin),
    .res           (lane_res[0])
  );

  efqt_lane u_lane1 (
    .ok            (s_tdata[17]),
    .frame         (s_tdata[33:18]),
    .current_angle (current_angle),
    .wrap_margin   (wrap_margin),
    .res           (lane_res[1])
  );

  // merge and state
  efqt_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fire          (fire),
    .op            (s_tuser),
    .lane_res      (lane_res),
    .current_angle (current_angle),
    .wrap_margin   (wrap_margin),
    .result        (result)
  );

  // output buffer
  efqt_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (result),
    .ready     (buf_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  // pack the result word; position is turns above the angle bits
  assign m_tdata = {2'b00, out_data.reinit_request, out_data.errfl_request,
                    out_data.turns, out_data.angle,
                    out_data.turns, out_data.angle};
  assign m_tuser = out_data.status;

endmodule

// File: test/tb_encoder_frame_qualifier_turn_tracker.sv
// ----------------------------------------------------------------------------
// tb_encoder_frame_qualifier_turn_tracker
// Self-checking bench for the encoder frame qualifier and turn tracker. Read
// and recovery words are streamed in with random gaps, results are drained
// with random back-pressure, and every result is compared field by field
// with a cycle-free prediction of parity checks, retries, failure streaks,
// reinit latching and multi-turn counting. Several register settings are
// visited, the extremes among them.
// ----------------------------------------------------------------------------
module tb_encoder_frame_qualifier_turn_tracker;
  import efqt_pkg::*;

  localparam int STALL_LIMIT = 4000;

  // scoreboard: predicts each result word and checks the drained ones
  class position_board;
    typedef struct {
      status_t               status;
      logic [ANGLE_BITS-1:0] angle;
      logic [TURN_BITS-1:0]  turns;
      logic [POS_BITS-1:0]   position;
      logic                  errfl;
      logic                  reinit;
    } track_result_t;

    logic [LIMIT_BITS-1:0]  fail_limit;
    logic [MARGIN_BITS-1:0] wrap_margin;
    logic [LIMIT_BITS-1:0]  miss_run;
    logic                   reinit_flag;
    logic [ANGLE_BITS-1:0]  cur_angle;
    logic [ANGLE_BITS-1:0]  prev_angle;
    logic [TURN_BITS-1:0]   turn_count;
    track_result_t          predicted_results[$];
    int mismatches;
    int results_seen;
    int status_seen[3];
    int turn_steps;
    int reinit_raised;

    function new();
      fail_limit  = FAIL_LIMIT_RST;
      wrap_margin = WRAP_MARGIN_RST;
      miss_run    = '0;
      reinit_flag = 1'b0;
      cur_angle   = '0;
      prev_angle  = '0;
      turn_count  = '0;
      mismatches  = 0;
      results_seen = 0;
      status_seen = '{0, 0, 0};
      turn_steps  = 0;
      reinit_raised = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_FAIL_LIMIT:  fail_limit = data[LIMIT_BITS-1:0];
        REG_WRAP_MARGIN: wrap_margin = data[MARGIN_BITS-1:0];
        default: ;
      endcase
    endfunction

    // transfer ok and even parity over bits 14:0
    function bit attempt_valid(bit ok, logic [FRAME_BITS-1:0] f);
      return ok && (f[PARITY_BIT] == ^f[PARITY_BIT-1:0]);
    endfunction

    // accepted frame: new angle, streak cleared, turn counted on a wide jump
    function void take_frame(logic [FRAME_BITS-1:0] f);
      int jump;
      int mag;
      prev_angle  = cur_angle;
      cur_angle   = f[ANGLE_BITS-1:0];
      miss_run    = '0;
      jump = int'(cur_angle) - int'(prev_angle);
      mag  = (jump < 0) ? -jump : jump;
      if (mag > int'(wrap_margin)) begin
        turn_steps++;
        if (jump > 0) turn_count = turn_count - 1;
        else turn_count = turn_count + 1;
      end
    endfunction

    function void take_word(op_t op, bit fo, logic [FRAME_BITS-1:0] ff,
                            bit ro, logic [FRAME_BITS-1:0] rf);
      track_result_t r;
      r.errfl = 1'b0;
      if (op == OP_RECOVER) begin
        reinit_flag = 1'b0;
        miss_run = '0;
        r.status = ST_STALE;
      end else if (reinit_flag) begin
        r.status = ST_ERROR;
      end else if (attempt_valid(fo, ff)) begin
        r.errfl = ff[ERRFL_BIT];
        take_frame(ff);
        r.status = ST_OK;
      end else begin
        r.errfl = 1'b1;
        if (attempt_valid(ro, rf)) begin
          take_frame(rf);
          r.status = ST_OK;
        end else begin
          if (miss_run != STREAK_MAX) miss_run++;
          if (miss_run >= fail_limit) begin
            reinit_flag = 1'b1;
            miss_run = '0;
            reinit_raised++;
          end
          r.status = reinit_flag ? ST_ERROR : ST_STALE;
        end
      end
      r.angle    = cur_angle;
      r.turns    = turn_count;
      r.position = {turn_count, cur_angle};
      r.reinit   = reinit_flag;
      status_seen[r.status]++;
      predicted_results.push_back(r);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got)
        flag($sformatf("result %0d %s expected %0h got %0h", results_seen, name, want, got));
    endfunction

    function void check_word(logic [95:0] data, logic [1:0] user);
      track_result_t want;
      if (predicted_results.size() == 0) begin
        flag("result word with nothing outstanding");
        return;
      end
      want = predicted_results.pop_front();
      check_field("status", 64'(want.status), 64'(user));
      check_field("angle", 64'(want.angle), 64'(data[13:0]));
      check_field("turns", 64'(want.turns), 64'(data[45:14]));
      check_field("position", 64'(want.position), 64'(data[91:46]));
      check_field("errfl_request", 64'(want.errfl), 64'(data[92]));
      check_field("reinit_request", 64'(want.reinit), 64'(data[93]));
      results_seen++;
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [39:0]              s_tdata;
  logic                     s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [95:0]              m_tdata;
  logic [1:0]               m_tuser;

  bit steady;
  int words_sent;
  int settings_used;
  int idle_cycles = 0;
  position_board board = new();

  encoder_frame_qualifier_turn_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // frame with correct parity
  function automatic logic [FRAME_BITS-1:0] good_frame(logic [ANGLE_BITS-1:0] ang, bit err);
    logic [FRAME_BITS-1:0] f;
    f = {1'b0, err, ang};
    f[PARITY_BIT] = ^f[PARITY_BIT-1:0];
    return f;
  endfunction

  // one failing attempt as {frame, ok}: bus error, bad parity, or a random frame with a bus error
  function automatic logic [FRAME_BITS:0] failed_attempt();
    logic [FRAME_BITS-1:0] f;
    f = good_frame(14'($urandom), 1'($urandom));
    case ($urandom_range(2))
      0: return {f, 1'b0};
      1: return {f ^ 16'h8000, 1'b1};
      default: return {16'($urandom), 1'b0};
    endcase
  endfunction

  // input word driver, random gaps before each word unless steady
  task automatic send_word(op_t op, bit fo, logic [FRAME_BITS-1:0] ff,
                           bit ro, logic [FRAME_BITS-1:0] rf);
    while (!steady && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, rf, ro, ff, fo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.take_word(op, fo, ff, ro, rf);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_failing_read();
    logic [FRAME_BITS:0] a;
    logic [FRAME_BITS:0] b;
    a = failed_attempt();
    b = failed_attempt();
    send_word(OP_READ, a[0], a[FRAME_BITS:1], b[0], b[FRAME_BITS:1]);
  endtask

  // let every outstanding result drain with the input idle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.predicted_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.set_register(idx, data);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_phase(logic [LIMIT_BITS-1:0] limit, logic [MARGIN_BITS-1:0] margin,
                           bit dirty_high);
    drain();
    write_register(REG_FAIL_LIMIT, {dirty_high ? 6'($urandom) : 6'b0, limit});
    write_register(REG_WRAP_MARGIN, margin);
    settings_used++;
  endtask

  // mostly well-formed angle walks, with failure bursts, recoveries and noise
  task automatic run_random(int n_words);
    int walk;
    int burst;
    int cap;
    int step;
    int r;
    bit recover_next;
    bit err;
    logic [FRAME_BITS:0] a;
    walk = int'(board.cur_angle);
    burst = 0;
    recover_next = 1'b0;
    for (int i = 0; i < n_words; i++) begin
      r = $urandom_range(99);
      if (recover_next || r < 4) begin
        recover_next = 1'b0;
        send_word(OP_RECOVER, 1'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
      end else if (r < 10) begin
        send_word(OP_READ, 1'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
      end else if (burst > 0 || r < 16) begin
        if (burst == 0) begin
          cap = (board.fail_limit <= 16) ? int'(board.fail_limit) + 1 : 20;
          burst = $urandom_range(1, cap);
        end
        send_failing_read();
        burst--;
        if (burst == 0) recover_next = board.reinit_flag && ($urandom_range(9) < 7);
      end else begin
        r = $urandom_range(99);
        if (r < 65) step = int'($urandom_range(0, 4000)) - 2000;
        else if (r < 85) step = int'($urandom_range(0, 32766)) - 16383;
        else begin
          step = int'(board.wrap_margin) + int'($urandom_range(0, 2)) - 1;
          if ($urandom_range(1) == 0) step = -step;
        end
        walk = (walk + step) & 16383;
        err = ($urandom_range(99) < 10);
        if ($urandom_range(99) < 85) begin
          send_word(OP_READ, 1'b1, good_frame(14'(walk), err), 1'($urandom), 16'($urandom));
        end else begin
          a = failed_attempt();
          send_word(OP_READ, a[0], a[FRAME_BITS:1], 1'b1, good_frame(14'(walk), err));
        end
      end
    end
  endtask

  // result sink with random back-pressure
  initial begin : result_sink
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= !rst && (steady || $urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata, m_tuser);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("** encoder_frame_qualifier_turn_tracker: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_FAIL_LIMIT;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_READ;
    steady    = 1'b0;
    words_sent = 0;
    settings_used = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words at reset settings: wraps, margin edges, retries, reinit
    send_word(OP_READ, 1'b1, 16'h0000, 1'b0, 16'h0000);
    send_word(OP_READ, 1'b1, 16'hFFFF, 1'b0, 16'h0000);
    send_word(OP_READ, 1'b1, good_frame(14'd0, 1'b0), 1'b1, 16'hFFFF);
    send_word(OP_READ, 1'b1, good_frame(14'd13107, 1'b0), 1'b0, 16'h0000);
    send_word(OP_READ, 1'b1, good_frame(14'd0, 1'b0), 1'b0, 16'h0000);
    send_word(OP_READ, 1'b1, good_frame(14'd13108, 1'b0), 1'b0, 16'h0000);
    send_word(OP_READ, 1'b1, good_frame(14'd0, 1'b1), 1'b0, 16'h0000);
    send_word(OP_READ, 1'b0, good_frame(14'd500, 1'b0), 1'b1, good_frame(14'd600, 1'b1));
    send_word(OP_READ, 1'b1, good_frame(14'd700, 1'b0) ^ 16'h8000,
              1'b1, good_frame(14'd800, 1'b0));
    send_word(OP_READ, 1'b0, good_frame(14'd900, 1'b0), 1'b0, good_frame(14'd900, 1'b0));
    send_word(OP_READ, 1'b1, 16'h8000, 1'b1, 16'h7FFF);
    send_word(OP_RECOVER, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
    repeat (4) send_failing_read();
    send_word(OP_READ, 1'b1, good_frame(14'd1234, 1'b1), 1'b1, 16'hFFFF);
    send_word(OP_RECOVER, 1'b0, 16'h0000, 1'b0, 16'h0000);
    send_word(OP_READ, 1'b1, good_frame(14'd16383, 1'b0), 1'b0, 16'h0000);
    send_word(OP_READ, 1'b0, 16'h0000, 1'b1, 16'hFFFF);
    run_random(220);

    // tightest limit, every angle change counts a turn
    set_phase(8'd1, 14'd0, 1'b0);
    run_random(220);

    // widest settings: a full streak to the top limit, turns never counted
    set_phase(8'd255, 14'd16383, 1'b0);
    repeat (256) send_failing_read();
    send_word(OP_RECOVER, 1'b1, 16'h0000, 1'b1, 16'h0000);
    run_random(150);

    // zero limit with junk in the upper data bits, both sides never idle
    set_phase(8'd0, 14'd8192, 1'b1);
    steady = 1'b1;
    run_random(220);
    steady = 1'b0;

    set_phase(8'd2, 14'd1, 1'b0);
    run_random(220);

    repeat (2) begin
      set_phase(8'($urandom_range(1, 16)), 14'($urandom), 1'b1);
      run_random(180);
    end

    drain();
    repeat (8) @(posedge clk);
    if (board.predicted_results.size() != 0)
      board.flag($sformatf("%0d results never arrived", board.predicted_results.size()));
    $display("covered %0d words over %0d register settings: %0d updated, %0d stale, %0d error",
             words_sent, settings_used, board.status_seen[ST_OK],
             board.status_seen[ST_STALE], board.status_seen[ST_ERROR]);
    $display("%0d turn steps, %0d reinit requests raised, %0d results checked, %0d mismatches",
             board.turn_steps, board.reinit_raised, board.results_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("** encoder_frame_qualifier_turn_tracker: PASSED **");
    end else begin
      $display("** encoder_frame_qualifier_turn_tracker: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/efqt_pkg.sv
sv/efqt_lane.sv
sv/efqt_core.sv
sv/efqt_obuf.sv
sv/encoder_frame_qualifier_turn_tracker.sv
test/tb_encoder_frame_qualifier_turn_tracker.sv
